@@ rtl/acc_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Event codes, set modes and the beat structures that pass between modules.
// ----------------------------------------------------------------------------
package acc_pkg;

    typedef enum logic [3:0] {
        REQ_TICK       = 4'd0,
        REQ_TIME_BTN   = 4'd1,
        REQ_ALARM_BTN  = 4'd2,
        REQ_ALARM_SW   = 4'd3,
        REQ_MIN_BTN    = 4'd4,
        REQ_HOUR_BTN   = 4'd5,
        REQ_QUERY      = 4'd6,
        REQ_LOAD       = 4'd7
    } req_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_TIME  = 2'd1,
        MODE_ALARM = 2'd2
    } mode_t;

    // One input beat as held in the input register.
    typedef struct packed {
        logic [3:0] req_type;
        logic [3:0] load_hour;
        logic [5:0] load_minute;
        logic       load_pm;
        logic [3:0] load_alarm_hour;
        logic [5:0] load_alarm_minute;
        logic       load_alarm_pm;
    } acc_event_t;

    // One result beat as held in the result register.
    typedef struct packed {
        logic [3:0] shown_hour;
        logic [5:0] shown_minute;
        logic       shown_pm;
        logic [1:0] current_mode;
        logic       alarm_enabled;
        logic       alarm_ringing;
    } acc_result_t;

endpackage

@@ rtl/alarm_clock_controller.sv @@
// ----------------------------------------------------------------------------
// Twelve-hour alarm clock controller
// Input register, event logic and result register; one result beat per event.
// ----------------------------------------------------------------------------
// Each input beat carries one event (minute tick, mode buttons, alarm switch,
// minute and hour buttons, display query or load) and yields exactly one
// result beat with the displayed time, mode, alarm enable and ringing flag as
// they stand after that event. A beat enters the input register and is
// applied to the clock state as it moves into the result register; one beat
// is taken every cycle while the result register is free or draining. Load
// fields matter only on a load event; unknown event codes leave the state
// unchanged.
module alarm_clock_controller (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_req_type,
    input  logic [3:0] s_load_hour,
    input  logic [5:0] s_load_minute,
    input  logic       s_load_pm,
    input  logic [3:0] s_load_alarm_hour,
    input  logic [5:0] s_load_alarm_minute,
    input  logic       s_load_alarm_pm,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_shown_hour,
    output logic [5:0] m_shown_minute,
    output logic       m_shown_pm,
    output logic [1:0] m_current_mode,
    output logic       m_alarm_enabled,
    output logic       m_alarm_ringing
);
    import acc_pkg::*;

    logic        in_valid_reg;
    acc_event_t  in_data_reg;
    logic        out_valid_reg;
    acc_result_t out_data_reg;
    acc_result_t core_result;
    logic        advance;

    // A held event moves on whenever the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg.req_type          <= s_req_type;
            in_data_reg.load_hour         <= s_load_hour;
            in_data_reg.load_minute       <= s_load_minute;
            in_data_reg.load_pm           <= s_load_pm;
            in_data_reg.load_alarm_hour   <= s_load_alarm_hour;
            in_data_reg.load_alarm_minute <= s_load_alarm_minute;
            in_data_reg.load_alarm_pm     <= s_load_alarm_pm;
        end
    end

    acc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .ev      (in_data_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_shown_hour    = out_data_reg.shown_hour;
    assign m_shown_minute  = out_data_reg.shown_minute;
    assign m_shown_pm      = out_data_reg.shown_pm;
    assign m_current_mode  = out_data_reg.current_mode;
    assign m_alarm_enabled = out_data_reg.alarm_enabled;
    assign m_alarm_ringing = out_data_reg.alarm_ringing;

endmodule

@@ rtl/acc_core.sv @@
// ----------------------------------------------------------------------------
// Alarm clock state and event logic
// Holds clock time, alarm time, set mode, enable and ringing flag; applies one
// event per cycle while fire is high and reports the display state after that event.
// ----------------------------------------------------------------------------
module acc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  acc_pkg::acc_event_t ev,
    output acc_pkg::acc_result_t result
);
    import acc_pkg::*;

    localparam logic [3:0] HOUR_TOP   = 4'd12;
    localparam logic [5:0] MINUTE_TOP = 6'd59;

    logic [3:0] clock_hour_reg, clock_hour_next;
    logic [5:0] clock_minute_reg, clock_minute_next;
    logic       clock_pm_reg, clock_pm_next;
    logic [3:0] wake_hour_reg, wake_hour_next;
    logic [5:0] wake_minute_reg, wake_minute_next;
    logic       wake_pm_reg, wake_pm_next;
    mode_t      set_mode_reg, set_mode_next;
    logic       alarm_armed_reg, alarm_armed_next;
    logic       ringing_reg, ringing_next;

    // Hours run 1..12; 12 wraps to 1.
    function automatic logic [3:0] hour_inc(input logic [3:0] h);
        return (h >= HOUR_TOP) ? 4'd1 : h + 4'd1;
    endfunction

    // The period flips whenever the hour becomes 12.
    function automatic logic pm_after(input logic [3:0] h, input logic pm);
        return (hour_inc(h) == HOUR_TOP) ? ~pm : pm;
    endfunction

    function automatic logic [5:0] minute_inc(input logic [5:0] m);
        return (m >= MINUTE_TOP) ? 6'd0 : m + 6'd1;
    endfunction

    function automatic logic [3:0] fix_hour(input logic [3:0] h);
        return (h >= 4'd1 && h <= HOUR_TOP) ? h : HOUR_TOP;
    endfunction

    function automatic logic [5:0] fix_minute(input logic [5:0] m);
        return (m <= MINUTE_TOP) ? m : MINUTE_TOP;
    endfunction

    always_comb begin
        clock_hour_next   = clock_hour_reg;
        clock_minute_next = clock_minute_reg;
        clock_pm_next     = clock_pm_reg;
        wake_hour_next    = wake_hour_reg;
        wake_minute_next  = wake_minute_reg;
        wake_pm_next      = wake_pm_reg;
        set_mode_next     = set_mode_reg;
        alarm_armed_next  = alarm_armed_reg;
        ringing_next      = ringing_reg;

        case (req_t'(ev.req_type))
            REQ_TICK: begin
                clock_minute_next = minute_inc(clock_minute_reg);
                if (clock_minute_reg >= MINUTE_TOP) begin
                    clock_hour_next = hour_inc(clock_hour_reg);
                    clock_pm_next   = pm_after(clock_hour_reg, clock_pm_reg);
                end
            end
            REQ_TIME_BTN: begin
                set_mode_next = (set_mode_reg == MODE_TIME) ? MODE_NONE : MODE_TIME;
            end
            REQ_ALARM_BTN: begin
                set_mode_next = (set_mode_reg == MODE_ALARM) ? MODE_NONE : MODE_ALARM;
            end
            REQ_ALARM_SW: begin
                alarm_armed_next = ~alarm_armed_reg;
                ringing_next     = 1'b0;
            end
            REQ_MIN_BTN: begin
                if (set_mode_reg == MODE_TIME) begin
                    clock_minute_next = minute_inc(clock_minute_reg);
                end else if (set_mode_reg == MODE_ALARM) begin
                    wake_minute_next = minute_inc(wake_minute_reg);
                end
            end
            REQ_HOUR_BTN: begin
                if (set_mode_reg == MODE_TIME) begin
                    clock_hour_next = hour_inc(clock_hour_reg);
                    clock_pm_next   = pm_after(clock_hour_reg, clock_pm_reg);
                end else if (set_mode_reg == MODE_ALARM) begin
                    wake_hour_next = hour_inc(wake_hour_reg);
                    wake_pm_next   = pm_after(wake_hour_reg, wake_pm_reg);
                end
            end
            REQ_QUERY: begin
                if (alarm_armed_reg && wake_hour_reg == clock_hour_reg &&
                    wake_minute_reg == clock_minute_reg && wake_pm_reg == clock_pm_reg) begin
                    ringing_next = 1'b1;
                end
            end
            REQ_LOAD: begin
                clock_hour_next   = fix_hour(ev.load_hour);
                clock_minute_next = fix_minute(ev.load_minute);
                clock_pm_next     = ev.load_pm;
                wake_hour_next    = fix_hour(ev.load_alarm_hour);
                wake_minute_next  = fix_minute(ev.load_alarm_minute);
                wake_pm_next      = ev.load_alarm_pm;
                set_mode_next     = MODE_NONE;
                alarm_armed_next  = 1'b0;
                ringing_next      = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // The result shows the state as it stands after this event.
    always_comb begin
        if (set_mode_next == MODE_ALARM) begin
            result.shown_hour   = wake_hour_next;
            result.shown_minute = wake_minute_next;
            result.shown_pm     = wake_pm_next;
        end else begin
            result.shown_hour   = clock_hour_next;
            result.shown_minute = clock_minute_next;
            result.shown_pm     = clock_pm_next;
        end
        result.current_mode  = set_mode_next;
        result.alarm_enabled = alarm_armed_next;
        result.alarm_ringing = ringing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hour_reg   <= HOUR_TOP;
            clock_minute_reg <= 6'd0;
            clock_pm_reg     <= 1'b0;
            wake_hour_reg    <= HOUR_TOP;
            wake_minute_reg  <= 6'd0;
            wake_pm_reg      <= 1'b0;
            set_mode_reg     <= MODE_NONE;
            alarm_armed_reg  <= 1'b0;
            ringing_reg      <= 1'b0;
        end else if (fire) begin
            clock_hour_reg   <= clock_hour_next;
            clock_minute_reg <= clock_minute_next;
            clock_pm_reg     <= clock_pm_next;
            wake_hour_reg    <= wake_hour_next;
            wake_minute_reg  <= wake_minute_next;
            wake_pm_reg      <= wake_pm_next;
            set_mode_reg     <= set_mode_next;
            alarm_armed_reg  <= alarm_armed_next;
            ringing_reg      <= ringing_next;
        end
    end

endmodule
